/* sv/dfe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the frame encoder.
// No dependencies; imported by dfe_serializer and dshot_frame_encoder_unit.
package dfe_pkg;

    localparam int FRAME_BITS   = 16;
    localparam int CNT_W        = $clog2(FRAME_BITS);
    localparam int THR_W        = 16;
    localparam int CLAMP_W      = 11;
    localparam int TICK_W       = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    localparam logic [CLAMP_W-1:0] THR_MIN_RST  = 11'd0;
    localparam logic [CLAMP_W-1:0] THR_MAX_RST  = 11'd2000;
    localparam logic [TICK_W-1:0]  ONE_HI_RST   = 8'd100;
    localparam logic [TICK_W-1:0]  ONE_LO_RST   = 8'd34;
    localparam logic [TICK_W-1:0]  ZERO_HI_RST  = 8'd50;
    localparam logic [TICK_W-1:0]  ZERO_LO_RST  = 8'd84;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THR_MIN = 3'd0,
        REG_THR_MAX = 3'd1,
        REG_ONE_HI  = 3'd2,
        REG_ONE_LO  = 3'd3,
        REG_ZERO_HI = 3'd4,
        REG_ZERO_LO = 3'd5
    } dfe_reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
    } dfe_ticks_t;

    typedef struct packed {
        logic                  chan;
        logic [FRAME_BITS-1:0] frame;
    } dfe_frame_t;

endpackage

/* sv/dshot_frame_encoder_unit.sv */
`timescale 1ns / 1ps
// Frame encoder top level: config registers, clamp and checksum pipeline.
// Depends on dfe_pkg and dfe_serializer.

// Each request (throttle, telemetry flag, motor channel) becomes one 16-bit
// frame, sent as 16 symbols, MSB first, one symbol per cycle while the output
// channel is not stalled; tlast marks the sixteenth. A request passes three
// pipeline stages (capture, clamp, frame build), then the serializer's shift
// register and one output register before its first symbol is offered. The
// next request is already taken while the current frame is still shifting
// out. Tick values come from the config registers when each symbol is
// produced, so write them only while the block is idle.
module dshot_frame_encoder_unit import dfe_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // throttle[15:0], telemetry_request[16]
    input  logic                  s_tuser,  // motor_channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // bit_value[0], high_ticks[8:1], low_ticks[16:9]
    output logic                  m_tuser,  // motor_channel_out
    output logic                  m_tlast   // last_symbol
);

    // config registers
    logic [CLAMP_W-1:0] thr_min_reg, thr_max_reg;
    dfe_ticks_t         ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_min_reg         <= THR_MIN_RST;
            thr_max_reg         <= THR_MAX_RST;
            ticks_reg.one_high  <= ONE_HI_RST;
            ticks_reg.one_low   <= ONE_LO_RST;
            ticks_reg.zero_high <= ZERO_HI_RST;
            ticks_reg.zero_low  <= ZERO_LO_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_THR_MIN: thr_min_reg         <= cfg_wdata;
                REG_THR_MAX: thr_max_reg         <= cfg_wdata;
                REG_ONE_HI:  ticks_reg.one_high  <= cfg_wdata[TICK_W-1:0];
                REG_ONE_LO:  ticks_reg.one_low   <= cfg_wdata[TICK_W-1:0];
                REG_ZERO_HI: ticks_reg.zero_high <= cfg_wdata[TICK_W-1:0];
                REG_ZERO_LO: ticks_reg.zero_low  <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and readiness
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic s1_ready, s2_ready, s3_ready, ser_ready;

    assign s3_ready = !s3_vld_reg || ser_ready;
    assign s2_ready = !s2_vld_reg || s3_ready;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign s_tready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_vld_reg <= s_tvalid;
            if (s2_ready) s2_vld_reg <= s1_vld_reg;
            if (s3_ready) s3_vld_reg <= s2_vld_reg;
        end
    end

    // stage 1: capture
    logic [THR_W-1:0] s1_thr_reg;
    logic             s1_telem_reg, s1_chan_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_thr_reg   <= s_tdata[THR_W-1:0];
            s1_telem_reg <= s_tdata[THR_W];
            s1_chan_reg  <= s_tuser;
        end
    end

    // stage 2: clamp; with crossed bounds, throttles below the lower bound get it, all others the upper
    logic [CLAMP_W-1:0] clamp_next, s2_clamp_reg;
    logic               s2_telem_reg, s2_chan_reg;

    always_comb begin
        if (s1_thr_reg < THR_W'(thr_min_reg)) begin
            clamp_next = thr_min_reg;
        end else if (s1_thr_reg > THR_W'(thr_max_reg)) begin
            clamp_next = thr_max_reg;
        end else begin
            clamp_next = s1_thr_reg[CLAMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_clamp_reg <= clamp_next;
            s2_telem_reg <= s1_telem_reg;
            s2_chan_reg  <= s1_chan_reg;
        end
    end

    // stage 3: 12-bit word plus nibble checksum
    logic [CLAMP_W:0] word;
    logic [3:0]       csum;
    dfe_frame_t       s3_frm_reg;

    assign word = {s2_clamp_reg, s2_telem_reg};
    assign csum = word[3:0] ^ word[7:4] ^ word[11:8];

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_frm_reg.frame <= {word, csum};
            s3_frm_reg.chan  <= s2_chan_reg;
        end
    end

    dfe_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frm_vld   (s3_vld_reg),
        .frm_ready (ser_ready),
        .frm       (s3_frm_reg),
        .ticks     (ticks_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* sv/dfe_serializer.sv */
`timescale 1ns / 1ps
// Frame serializer: shifts a 16-bit frame out MSB first, into a registered
// output channel, one symbol per cycle unless stalled. Depends on dfe_pkg.
module dfe_serializer import dfe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 frm_vld,
    output logic                 frm_ready,
    input  dfe_frame_t           frm,
    input  dfe_ticks_t           ticks,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // bit_value, high_ticks, low_ticks
    output logic                 m_tuser,  // motor_channel_out
    output logic                 m_tlast   // last_symbol
);

    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  chan_reg, chan_next;
    logic                  ovld_reg, ovld_next;
    logic [M_TDATA_W-1:0]  odata_reg, odata_next;
    logic                  ouser_reg, ouser_next;
    logic                  olast_reg, olast_next;

    logic out_load;
    logic is_last;
    logic bit_v;
    logic take;

    assign out_load  = busy_reg && (!ovld_reg || m_tready);
    assign is_last   = (cnt_reg == CNT_W'(FRAME_BITS - 1));
    assign bit_v     = shift_reg[FRAME_BITS-1];
    assign frm_ready = !busy_reg || (out_load && is_last);
    assign take      = frm_vld && frm_ready;

    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        chan_next  = chan_reg;
        ovld_next  = ovld_reg;
        odata_next = odata_reg;
        ouser_next = ouser_reg;
        olast_next = olast_reg;

        if (m_tready) begin
            ovld_next = 1'b0;
        end
        if (out_load) begin
            ovld_next  = 1'b1;
            odata_next = {(M_TDATA_W - 2*TICK_W - 1)'(0),
                          bit_v ? ticks.one_low  : ticks.zero_low,
                          bit_v ? ticks.one_high : ticks.zero_high,
                          bit_v};
            ouser_next = chan_reg;
            olast_next = is_last;
            shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        // a frame loads when idle or as the previous one drains its last symbol
        if (take) begin
            shift_next = frm.frame;
            chan_next  = frm.chan;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ovld_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            ovld_reg <= ovld_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        chan_reg  <= chan_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dshot_frame_encoder_unit: a directed table, then
// random requests under several register settings with random stalls.
// Depends on dfe_pkg and the encoder RTL.
module testbench;
    import dfe_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_DIRECTED    = 14;

    typedef struct packed {
        logic              chan;
        logic              bit_val;
        logic [TICK_W-1:0] hi_ticks;
        logic [TICK_W-1:0] lo_ticks;
        logic              last;
    } symbol_t;

    typedef struct packed {
        logic [THR_W-1:0]      thr;
        logic                  tel;
        logic                  ch;
        logic                  typed;  // frame column holds the expected frame
        logic [FRAME_BITS-1:0] frame;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // local copy of the register file
    logic [CLAMP_W-1:0] mdl_thr_min;
    logic [CLAMP_W-1:0] mdl_thr_max;
    dfe_ticks_t         mdl_ticks;

    symbol_t pending_symbols[$];
    int      symbols_checked = 0;
    int      failures = 0;
    int      idle_cycles = 0;

    // Typed frames below hold for the reset bounds 0..2000.
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000},
        '{16'h0000, 1'b1, 1'b1, 1'b1, 16'h0011},
        '{16'hFFFF, 1'b0, 1'b0, 1'b1, 16'hFA05},
        '{16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFA14},
        '{16'd2000, 1'b0, 1'b1, 1'b1, 16'hFA05},
        '{16'd2001, 1'b1, 1'b0, 1'b1, 16'hFA14},
        '{16'd1999, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h8000, 1'b1, 1'b1, 1'b0, 16'h0000},
        '{16'h07FF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0555, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{16'h02AA, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h7FFF, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{16'h0400, 1'b0, 1'b1, 1'b0, 16'h0000}
    };

    dshot_frame_encoder_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // clamp, shift in telemetry, append nibble checksum
    function automatic logic [FRAME_BITS-1:0] dshot_frame(input logic [THR_W-1:0] thr,
                                                          input logic tel);
        logic [CLAMP_W-1:0] clamped;
        logic [11:0]        word;
        logic [3:0]         csum;
        if (thr < mdl_thr_min)
            clamped = mdl_thr_min;
        else if (thr > mdl_thr_max)
            clamped = mdl_thr_max;
        else
            clamped = thr[CLAMP_W-1:0];
        word = {clamped, tel};
        csum = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, csum};
    endfunction

    function automatic void queue_frame_symbols(input logic [FRAME_BITS-1:0] frame,
                                                input logic ch);
        symbol_t s;
        for (int k = 0; k < FRAME_BITS; k++) begin
            s.chan     = ch;
            s.bit_val  = frame[FRAME_BITS-1-k];
            s.hi_ticks = s.bit_val ? mdl_ticks.one_high : mdl_ticks.zero_high;
            s.lo_ticks = s.bit_val ? mdl_ticks.one_low : mdl_ticks.zero_low;
            s.last     = (k == FRAME_BITS - 1);
            pending_symbols.push_back(s);
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [THR_W-1:0] random_throttle();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
            v = $urandom_range(0, 65535);
        else if (r < 6)
            v = int'(mdl_thr_min) + int'($urandom_range(0, 6)) - 3;
        else if (r < 8)
            v = int'(mdl_thr_max) + int'($urandom_range(0, 6)) - 3;
        else
            v = $urandom_range(0, 2047);
        if (v < 0)
            v = 0;
        return v[THR_W-1:0];
    endfunction

    task automatic send_request(input logic [THR_W-1:0] thr, input logic tel, input logic ch,
                                input logic typed, input logic [FRAME_BITS-1:0] typed_frame,
                                input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-THR_W-1){1'b0}}, tel, thr};
        s_tuser  <= ch;
        do @(posedge aclk); while (!s_tready);
        queue_frame_symbols(typed ? typed_frame : dshot_frame(thr, tel), ch);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_THR_MIN: mdl_thr_min = val;
            REG_THR_MAX: mdl_thr_max = val;
            REG_ONE_HI:  mdl_ticks.one_high  = val[TICK_W-1:0];
            REG_ONE_LO:  mdl_ticks.one_low   = val[TICK_W-1:0];
            REG_ZERO_HI: mdl_ticks.zero_high = val[TICK_W-1:0];
            REG_ZERO_LO: mdl_ticks.zero_low  = val[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // tick writes carry random junk above bit 7; spare indexes must be ignored
    task automatic apply_config(input logic [CLAMP_W-1:0] tmin, input logic [CLAMP_W-1:0] tmax,
                                input logic [TICK_W-1:0] one_hi, input logic [TICK_W-1:0] one_lo,
                                input logic [TICK_W-1:0] zero_hi,
                                input logic [TICK_W-1:0] zero_lo);
        wait_idle();
        write_reg(REG_THR_MIN, tmin);
        write_reg(REG_THR_MAX, tmax);
        write_reg(REG_ONE_HI,  {3'($urandom_range(0, 7)), one_hi});
        write_reg(REG_ONE_LO,  {3'($urandom_range(0, 7)), one_lo});
        write_reg(REG_ZERO_HI, {3'($urandom_range(0, 7)), zero_hi});
        write_reg(REG_ZERO_LO, {3'($urandom_range(0, 7)), zero_lo});
        write_reg(REG_SPARE_6, 11'($urandom_range(0, 2047)));
        write_reg(REG_SPARE_7, 11'($urandom_range(0, 2047)));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_requests(input int count);
        bit calm;
        int gap;
        calm = 0;
        for (int k = 0; k < count; k++) begin
            if (k % 8 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = (calm || $urandom_range(0, 1) == 0) ? 0 : rand_gap();
            send_request(random_throttle(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'b0, '0, gap);
        end
    endtask

    initial begin
        int tmin;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        mdl_thr_min = THR_MIN_RST;
        mdl_thr_max = THR_MAX_RST;
        mdl_ticks   = '{ONE_HI_RST, ONE_LO_RST, ZERO_HI_RST, ZERO_LO_RST};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].thr, directed_rows[i].tel, directed_rows[i].ch,
                         directed_rows[i].typed, directed_rows[i].frame,
                         (i % 3 == 0) ? rand_gap() : 0);

        // crossed bounds at the extremes, zero durations
        apply_config(11'd2047, 11'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_random_requests(ITEMS_PER_PHASE);
        // full range, tick extremes
        apply_config(11'd0, 11'd2047, 8'd255, 8'd0, 8'd0, 8'd255);
        run_random_requests(ITEMS_PER_PHASE);
        apply_config(11'd1500, 11'd100, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random_requests(ITEMS_PER_PHASE);
        repeat (2) begin
            tmin = $urandom_range(0, 1000);
            apply_config(11'(tmin), 11'($urandom_range(tmin, 2047)), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
            run_random_requests(ITEMS_PER_PHASE);
        end
        apply_config(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
        run_random_requests(ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && pending_symbols.size() == 0)
            $display("dshot_frame_encoder_unit: match");
        else
            $display("dshot_frame_encoder_unit: mismatch");
        $finish;
    end

    // symbol sink: random stalls, calm stretches, and one long hold-off
    initial begin
        int gap_left;
        bit calm;
        bit held;
        gap_left = 0;
        calm = 0;
        held = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && symbols_checked >= HOLD_AFTER) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (gap_left > 0) begin
                m_tready <= 1'b0;
                gap_left--;
            end else begin
                if ($urandom_range(0, 63) == 0)
                    calm = !calm;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    gap_left = rand_gap() - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        symbol_t got;
        symbol_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[0], m_tdata[8:1], m_tdata[16:9], m_tlast};
            symbols_checked++;
            if (pending_symbols.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected symbol: chan %0d bit %0d hi %0d lo %0d last %0d",
                             got.chan, got.bit_val, got.hi_ticks, got.lo_ticks, got.last);
            end else begin
                want = pending_symbols.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display({"symbol %0d: expected chan %0d bit %0d hi %0d lo %0d last %0d,",
                                  " got chan %0d bit %0d hi %0d lo %0d last %0d"},
                                 symbols_checked, want.chan, want.bit_val, want.hi_ticks,
                                 want.lo_ticks, want.last, got.chan, got.bit_val, got.hi_ticks,
                                 got.lo_ticks, got.last);
                end
            end
        end
    end

    // no request moving on either side for too long means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dshot_frame_encoder_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
